FILE: hdl/hza_pkg.sv
// ----------------------------------------------------------------------------
// hza_pkg
// Shared widths, defaults and types for the Householder alignment pipeline.
// ----------------------------------------------------------------------------
package hza_pkg;

	localparam int IN_WIDTH_DEF  = 16;
	localparam int FRAC_BITS_DEF = 14;

	// The largest normalized cross product magnitude lies in [2^29, 2^30).
	localparam int NORM_W     = 30;
	// Sum of three squares of normalized magnitudes stays below 2^62.
	localparam int L2_W       = 62;
	// One result bit of the integer square root per stage.
	localparam int SQRT_STEPS = 31;
	localparam int ROOT_W     = 31;
	// Width of numerators and of the denominator of the matrix quotients.
	localparam int PROD_W     = 64;
	localparam int OUT_W      = 16;

	typedef struct packed {
		logic [NORM_W-1:0] w0;
		logic [NORM_W-1:0] w1;
		logic [NORM_W-1:0] w2;
		logic              neg0;
		logic              neg1;
		logic              deg;
	} side_t;

	typedef struct packed {
		logic [8:0][OUT_W-1:0] r;
		logic                  deg;
	} result_t;

endpackage

FILE: hdl/hza_isqrt.sv
// ----------------------------------------------------------------------------
// hza_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module hza_isqrt import hza_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [L2_W-1:0]   x,
	output logic [ROOT_W-1:0] root
);

	logic [L2_W-1:0] x_sn   [0:SQRT_STEPS];
	logic [L2_W-1:0] res_sn [0:SQRT_STEPS];

	assign x_sn[0]   = x;
	assign res_sn[0] = '0;

	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_step
		localparam logic [L2_W-1:0] BIT = L2_W'(1) << (L2_W - 2 - 2*(k-1));
		logic [L2_W:0] trial;

		assign trial = {1'b0, res_sn[k-1]} + {1'b0, BIT};

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, x_sn[k-1]} >= trial) begin
					x_sn[k]   <= x_sn[k-1] - trial[L2_W-1:0];
					res_sn[k] <= (res_sn[k-1] >> 1) + BIT;
				end else begin
					x_sn[k]   <= x_sn[k-1];
					res_sn[k] <= res_sn[k-1] >> 1;
				end
			end
		end
	end

	assign root = res_sn[SQRT_STEPS][ROOT_W-1:0];

endmodule

FILE: hdl/hza_div.sv
// ----------------------------------------------------------------------------
// hza_div
// Pipelined restoring divider: two integer quotient bits, then FRAC_BITS+1
// fraction bits, one bit per register stage.
// ----------------------------------------------------------------------------
module hza_div import hza_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [PROD_W-1:0]    num,
	input  logic [PROD_W-1:0]    den,
	output logic [FRAC_BITS+2:0] quot
);

	localparam int QB = FRAC_BITS + 3;

	logic [PROD_W:0]   rem_sn [0:QB];
	logic [PROD_W-1:0] den_sn [0:QB];
	logic [QB-1:0]     q_sn   [0:QB];

	assign rem_sn[0] = {1'b0, num};
	assign den_sn[0] = den;
	assign q_sn[0]   = '0;

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [PROD_W:0] base;
		logic [PROD_W:0] trial;

		// The quotient never exceeds two, so the first stage tests 2*den.
		if (k == 1) begin : g_two
			assign base  = rem_sn[k-1];
			assign trial = {den_sn[k-1], 1'b0};
		end else if (k == 2) begin : g_one
			assign base  = rem_sn[k-1];
			assign trial = {1'b0, den_sn[k-1]};
		end else begin : g_frac
			assign base  = rem_sn[k-1] << 1;
			assign trial = {1'b0, den_sn[k-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_sn[k] <= den_sn[k-1];
				if (base >= trial) begin
					rem_sn[k] <= base - trial;
					q_sn[k]   <= {q_sn[k-1][QB-2:0], 1'b1};
				end else begin
					rem_sn[k] <= base;
					q_sn[k]   <= {q_sn[k-1][QB-2:0], 1'b0};
				end
			end
		end
	end

	assign quot = q_sn[QB];

endmodule

FILE: hdl/householder_align_to_z.sv
// ----------------------------------------------------------------------------
// householder_align_to_z
// Reflection matrix that maps the unit axis of m x n onto +z, in signed
// fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one vector pair m, n per
//   transaction; the output channel (out_valid/out_ready) carries the nine
//   matrix entries r_00..r_22 and the degenerate flag per transaction.
//   A fully pipelined datapath takes one pair per cycle while the output
//   buffer has room. Most of the depth comes from the bit-per-stage square
//   root (31 stages) and the bit-per-stage dividers (FRAC_BITS + 3 stages).
//   A two-entry output buffer follows the pipeline. The pipeline advances
//   while that buffer holds fewer than two results, so input is taken while
//   one result waits; with two waiting the whole pipeline holds its contents.
//   Reset clears all valid bits and empties the output buffer.
//   When m and n are parallel or zero the matrix is all zero and degenerate
//   is high.
// ----------------------------------------------------------------------------
module householder_align_to_z import hza_pkg::*; #(
	parameter int IN_WIDTH  = IN_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [IN_WIDTH-1:0] m_x,
	input  logic signed [IN_WIDTH-1:0] m_y,
	input  logic signed [IN_WIDTH-1:0] m_z,
	input  logic signed [IN_WIDTH-1:0] n_x,
	input  logic signed [IN_WIDTH-1:0] n_y,
	input  logic signed [IN_WIDTH-1:0] n_z,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OUT_W-1:0]    r_00,
	output logic signed [OUT_W-1:0]    r_01,
	output logic signed [OUT_W-1:0]    r_02,
	output logic signed [OUT_W-1:0]    r_10,
	output logic signed [OUT_W-1:0]    r_11,
	output logic signed [OUT_W-1:0]    r_12,
	output logic signed [OUT_W-1:0]    r_20,
	output logic signed [OUT_W-1:0]    r_21,
	output logic signed [OUT_W-1:0]    r_22,
	output logic                       degenerate
);

	localparam int PW    = 2 * IN_WIDTH;
	localparam int CW    = PW + 1;
	localparam int NW    = (CW > NORM_W) ? CW : NORM_W;
	localparam int NSH   = $clog2(NW);
	localparam int QB    = FRAC_BITS + 3;
	localparam int NPIPE = 7 + NSH + SQRT_STEPS + QB;
	localparam int VW    = 40;

	logic             adv;
	logic [NPIPE-1:0] vld_q;
	logic [1:0]       cnt_q;
	logic             wr_q;
	logic             rd_q;
	logic             push;
	logic             pop;

	// The whole pipeline moves together while the output buffer has room.
	assign adv      = (cnt_q != 2'd2);
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NPIPE-2:0], in_valid};
		end
	end

	// Stage 1: the six cross product terms.
	logic signed [PW-1:0] p_s1 [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= m_y * n_z;
			p_s1[1] <= m_z * n_y;
			p_s1[2] <= m_z * n_x;
			p_s1[3] <= m_x * n_z;
			p_s1[4] <= m_x * n_y;
			p_s1[5] <= m_y * n_x;
		end
	end

	// Stage 2: cross product.
	logic signed [CW-1:0] c_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2[0] <= CW'(p_s1[0]) - CW'(p_s1[1]);
			c_s2[1] <= CW'(p_s1[2]) - CW'(p_s1[3]);
			c_s2[2] <= CW'(p_s1[4]) - CW'(p_s1[5]);
		end
	end

	// Stage 3: magnitudes and signs; the signs flip when z is negative.
	logic [NW-1:0] nrm_sn [0:NSH][3];
	logic [NSH:0]  nn0_sn;
	logic [NSH:0]  nn1_sn;
	logic [NSH:0]  ndg_sn;
	logic [CW-1:0] abs_c  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_c[i] = c_s2[i][CW-1] ? CW'(-c_s2[i]) : CW'(c_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nrm_sn[0][i] <= NW'(abs_c[i][PW-1:0]);
			end
			nn0_sn[0] <= c_s2[0][CW-1] ^ c_s2[2][CW-1];
			nn1_sn[0] <= c_s2[1][CW-1] ^ c_s2[2][CW-1];
			ndg_sn[0] <= (c_s2[0] == '0) && (c_s2[1] == '0) && (c_s2[2] == '0);
		end
	end

	// Normalization: left-align the largest magnitude, one shift step per stage.
	for (genvar j = 0; j < NSH; j++) begin : g_norm
		localparam int SH = 1 << (NSH - 1 - j);
		logic [NW-1:0] orv;
		logic          top_zero;

		assign orv      = nrm_sn[j][0] | nrm_sn[j][1] | nrm_sn[j][2];
		assign top_zero = (orv[NW-1 -: SH] == '0);

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					nrm_sn[j+1][i] <= top_zero ? (nrm_sn[j][i] << SH) : nrm_sn[j][i];
				end
				nn0_sn[j+1] <= nn0_sn[j];
				nn1_sn[j+1] <= nn1_sn[j];
				ndg_sn[j+1] <= ndg_sn[j];
			end
		end
	end

	// Extract the top bits (truncation toward zero) and square them.
	logic [NORM_W-1:0]   mg_c  [3];
	logic [NORM_W-1:0]   mg_s4 [3];
	logic [2*NORM_W-1:0] sq_s4 [3];
	logic                ng0_s4;
	logic                ng1_s4;
	logic                dg_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mg_c[i] = nrm_sn[NSH][i][NW-1 -: NORM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				mg_s4[i] <= mg_c[i];
				sq_s4[i] <= mg_c[i] * mg_c[i];
			end
			ng0_s4 <= nn0_sn[NSH] && (mg_c[0] != '0);
			ng1_s4 <= nn1_sn[NSH] && (mg_c[1] != '0);
			dg_s4  <= ndg_sn[NSH];
		end
	end

	// Squared length.
	logic [L2_W-1:0] l2_s5;
	side_t           side_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			l2_s5        <= L2_W'(sq_s4[0]) + L2_W'(sq_s4[1]) + L2_W'(sq_s4[2]);
			side_s5.w0   <= mg_s4[0];
			side_s5.w1   <= mg_s4[1];
			side_s5.w2   <= mg_s4[2];
			side_s5.neg0 <= ng0_s4;
			side_s5.neg1 <= ng1_s4;
			side_s5.deg  <= dg_s4;
		end
	end

	// Square root, with the side data delayed alongside.
	logic [ROOT_W-1:0] len_c;
	side_t             sd_sn [0:SQRT_STEPS];

	hza_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.x    (l2_s5),
		.root (len_c)
	);

	assign sd_sn[0] = side_s5;

	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sd
		always_ff @(posedge clk) begin
			if (adv) begin
				sd_sn[k] <= sd_sn[k-1];
			end
		end
	end

	// w = (cx, cy, cz + L).
	logic [ROOT_W-1:0] len_s6;
	logic [ROOT_W:0]   w2_s6;
	side_t             sd_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s6 <= len_c;
			w2_s6  <= (ROOT_W+1)'(sd_sn[SQRT_STEPS].w2) + (ROOT_W+1)'(len_c);
			sd_s6  <= sd_sn[SQRT_STEPS];
		end
	end

	// Numerators w_i w_j and denominator L (L + cz).
	logic [PROD_W-1:0] num_s7 [6];
	logic [PROD_W-1:0] den_s7;
	logic [2:0]        dd_sn  [0:QB];

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s7[0] <= PROD_W'(sd_s6.w0 * sd_s6.w0);
			num_s7[1] <= PROD_W'(sd_s6.w0 * sd_s6.w1);
			num_s7[2] <= PROD_W'(sd_s6.w0 * w2_s6);
			num_s7[3] <= PROD_W'(sd_s6.w1 * sd_s6.w1);
			num_s7[4] <= PROD_W'(sd_s6.w1 * w2_s6);
			num_s7[5] <= PROD_W'(w2_s6 * w2_s6);
			den_s7    <= PROD_W'(len_s6 * w2_s6);
			dd_sn[0]  <= {sd_s6.neg0, sd_s6.neg1, sd_s6.deg};
		end
	end

	// Six quotients of the symmetric matrix.
	logic [QB-1:0] q_c [6];

	for (genvar e = 0; e < 6; e++) begin : g_div
		hza_div #(
			.FRAC_BITS (FRAC_BITS)
		) u_div (
			.clk  (clk),
			.en   (adv),
			.num  (num_s7[e]),
			.den  (den_s7),
			.quot (q_c[e])
		);
	end

	for (genvar k = 1; k <= QB; k++) begin : g_dd
		always_ff @(posedge clk) begin
			if (adv) begin
				dd_sn[k] <= dd_sn[k-1];
			end
		end
	end

	// Round half away from zero, apply the sign, subtract I, saturate.
	function automatic logic [OUT_W-1:0] finish(input logic [QB-1:0] q, input logic ng,
	                                            input logic dg);
		logic [QB:0]      qp;
		logic signed [VW-1:0] v;
		qp = {1'b0, q} + (QB+1)'(1);
		v  = VW'(qp[QB:1]);
		if (ng) begin
			v = -v;
		end
		if (dg) begin
			v = v - (VW'(1) <<< FRAC_BITS);
		end
		if (v > VW'(32767)) begin
			v = VW'(32767);
		end else if (v < -VW'(32768)) begin
			v = -VW'(32768);
		end
		return v[OUT_W-1:0];
	endfunction

	result_t fin_c;
	logic    sg0;
	logic    sg1;
	logic    sdg;

	assign sg0 = dd_sn[QB][2];
	assign sg1 = dd_sn[QB][1];
	assign sdg = dd_sn[QB][0];

	always_comb begin
		fin_c.deg  = sdg;
		fin_c.r[0] = finish(q_c[0], 1'b0, 1'b1);
		fin_c.r[1] = finish(q_c[1], sg0 ^ sg1, 1'b0);
		fin_c.r[2] = finish(q_c[2], sg0, 1'b0);
		fin_c.r[3] = fin_c.r[1];
		fin_c.r[4] = finish(q_c[3], 1'b0, 1'b1);
		fin_c.r[5] = finish(q_c[4], sg1, 1'b0);
		fin_c.r[6] = fin_c.r[2];
		fin_c.r[7] = fin_c.r[5];
		fin_c.r[8] = finish(q_c[5], 1'b0, 1'b1);
		if (sdg) begin
			fin_c.r = '0;
		end
	end

	// Two-entry output buffer.
	result_t buf_q [2];

	assign push      = adv && vld_q[NPIPE-1];
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= fin_c;
		end
	end

	assign r_00       = buf_q[rd_q].r[0];
	assign r_01       = buf_q[rd_q].r[1];
	assign r_02       = buf_q[rd_q].r[2];
	assign r_10       = buf_q[rd_q].r[3];
	assign r_11       = buf_q[rd_q].r[4];
	assign r_12       = buf_q[rd_q].r[5];
	assign r_20       = buf_q[rd_q].r[6];
	assign r_21       = buf_q[rd_q].r[7];
	assign r_22       = buf_q[rd_q].r[8];
	assign degenerate = buf_q[rd_q].deg;

endmodule

FILE: hdl/hza_chk.sv
// ----------------------------------------------------------------------------
// hza_chk
// Port-level checks on the result channel of householder_align_to_z.
// ----------------------------------------------------------------------------
module hza_chk import hza_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] r_00,
	input logic signed [OUT_W-1:0] r_01,
	input logic signed [OUT_W-1:0] r_02,
	input logic signed [OUT_W-1:0] r_10,
	input logic signed [OUT_W-1:0] r_11,
	input logic signed [OUT_W-1:0] r_12,
	input logic signed [OUT_W-1:0] r_20,
	input logic signed [OUT_W-1:0] r_21,
	input logic signed [OUT_W-1:0] r_22,
	input logic                    degenerate
);

	// A degenerate transaction carries an all-zero matrix.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> r_00 == 0 && r_01 == 0 && r_02 == 0 &&
		r_10 == 0 && r_11 == 0 && r_12 == 0 && r_20 == 0 && r_21 == 0 && r_22 == 0)
		else $error("degenerate result with nonzero matrix");

	// The reflection is symmetric.
	a_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> r_01 == r_10 && r_02 == r_20 && r_12 == r_21)
		else $error("result matrix is not symmetric");

	// The z entry equals cz / L with cz made nonnegative.
	a_r22_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> r_22 >= 0)
		else $error("r_22 negative on a regular result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(r_00) && $stable(r_01) &&
		$stable(r_02) && $stable(r_11) && $stable(r_12) && $stable(r_22) &&
		$stable(degenerate))
		else $error("stalled result changed");

endmodule

bind householder_align_to_z hza_chk u_hza_chk (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for householder_align_to_z. A short table of directed
// vector pairs runs first, then about a thousand random pairs. Every output
// transaction is checked against a bit-exact predictor of the reflection
// matrix, with random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import hza_pkg::*;

	localparam int N_RANDOM  = 1080;
	localparam int ONE_Q     = 1 << FRAC_BITS_DEF;
	localparam int HOLD_LEN  = 300;

	typedef logic signed [IN_WIDTH_DEF-1:0] comp_t;

	typedef struct {
		comp_t   m [3];
		comp_t   n [3];
		bit      has_exp;
		result_t exp_res;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	comp_t m_x = '0, m_y = '0, m_z = '0, n_x = '0, n_y = '0, n_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] r_00, r_01, r_02, r_10, r_11, r_12, r_20, r_21, r_22;
	logic degenerate;

	result_t matrix_q [$];
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	bit      long_hold = 1'b0;
	bit      failed = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	householder_align_to_z u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.m_x(m_x), .m_y(m_y), .m_z(m_z), .n_x(n_x), .n_y(n_y), .n_z(n_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.r_00(r_00), .r_01(r_01), .r_02(r_02),
		.r_10(r_10), .r_11(r_11), .r_12(r_12),
		.r_20(r_20), .r_21(r_21), .r_22(r_22),
		.degenerate(degenerate)
	);

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Rounds num * 2^FRAC_BITS / den to nearest, ties away from zero.
	function automatic longint unsigned round_quot(longint unsigned num, longint unsigned den);
		longint unsigned q, r;
		q = num / den;
		r = num % den;
		for (int k = 0; k <= FRAC_BITS_DEF; k++) begin
			q <<= 1;
			r <<= 1;
			if (r >= den) begin
				r -= den;
				q++;
			end
		end
		return (q + 1) >> 1;
	endfunction

	function automatic result_t align_matrix(comp_t m [3], comp_t n [3]);
		result_t res;
		longint c [3];
		longint unsigned mag [3], w [3], mx, len, den;
		bit neg [3];
		longint val;
		bit ni, nj;
		res = '0;
		c[0] = longint'(m[1]) * n[2] - longint'(m[2]) * n[1];
		c[1] = longint'(m[2]) * n[0] - longint'(m[0]) * n[2];
		c[2] = longint'(m[0]) * n[1] - longint'(m[1]) * n[0];
		if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
			res.deg = 1'b1;
			return res;
		end
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i] < 0;
			mag[i] = neg[i] ? -c[i] : c[i];
		end
		// Flip the whole axis so that its z component is non-negative.
		if (neg[2])
			for (int i = 0; i < 3; i++) neg[i] = !neg[i];
		mx = mag[0];
		if (mag[1] > mx) mx = mag[1];
		if (mag[2] > mx) mx = mag[2];
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		for (int i = 0; i < 3; i++)
			if (mag[i] == 0) neg[i] = 1'b0;
		len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
		w[0] = mag[0];
		w[1] = mag[1];
		w[2] = mag[2] + len;
		den = len * w[2];
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				ni = (i < 2) ? neg[i] : 1'b0;
				nj = (j < 2) ? neg[j] : 1'b0;
				val = longint'(round_quot(w[i] * w[j], den));
				if (ni != nj) val = -val;
				if (i == j) val -= ONE_Q;
				if (val > 32767) val = 32767;
				if (val < -32768) val = -32768;
				res.r[i * 3 + j] = val[OUT_W-1:0];
			end
		end
		return res;
	endfunction

	function automatic result_t z_aligned();
		result_t res;
		res = '0;
		res.r[0] = OUT_W'(-ONE_Q);
		res.r[4] = OUT_W'(-ONE_Q);
		res.r[8] = OUT_W'(ONE_Q);
		return res;
	endfunction

	function automatic result_t zero_degenerate();
		result_t res;
		res = '0;
		res.deg = 1'b1;
		return res;
	endfunction

	function automatic vec_row_t make_row(int mx, int my, int mz, int nx, int ny, int nz,
			bit has_exp, result_t exp_res);
		vec_row_t row;
		row.m[0] = comp_t'(mx); row.m[1] = comp_t'(my); row.m[2] = comp_t'(mz);
		row.n[0] = comp_t'(nx); row.n[1] = comp_t'(ny); row.n[2] = comp_t'(nz);
		row.has_exp = has_exp;
		row.exp_res = exp_res;
		return row;
	endfunction

	task automatic send_pair(comp_t m [3], comp_t n [3], bit has_exp, result_t exp_res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		m_x <= m[0]; m_y <= m[1]; m_z <= m[2];
		n_x <= n[0]; n_y <= n[1]; n_z <= n[2];
		do @(posedge clk); while (!in_ready);
		matrix_q.push_back(has_exp ? exp_res : align_matrix(m, n));
		@(negedge clk);
	endtask

	function automatic comp_t rand_comp();
		case ($urandom_range(5))
			0: return comp_t'(int'($urandom_range(7)) - 3);
			1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return comp_t'($urandom);
		endcase
	endfunction

	// Output side: random stalls, one long hold-off on request, and the check.
	initial begin : output_side
		result_t got, want;
		int hold_cnt;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (long_hold && hold_cnt == 0) hold_cnt = HOLD_LEN;
			if (hold_cnt > 0) begin
				hold_cnt--;
				if (hold_cnt == 0) long_hold = 1'b0;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.r = {r_22, r_21, r_20, r_12, r_11, r_10, r_02, r_01, r_00};
				got.deg = degenerate;
				if (matrix_q.size() == 0) begin
					$error("output transaction with no expected matrix");
					failed = 1'b1;
				end else begin
					want = matrix_q.pop_front();
					for (int k = 0; k < 9; k++)
						if (got.r[k] !== want.r[k]) begin
							$error("r_%0d%0d: expected %0d, got %0d", k / 3, k % 3,
								$signed(want.r[k]), $signed(got.r[k]));
							failed = 1'b1;
						end
					if (got.deg !== want.deg) begin
						$error("degenerate: expected %0b, got %0b", want.deg, got.deg);
						failed = 1'b1;
					end
				end
			end
		end
	end

	initial begin : stimulus
		vec_row_t rows [$];
		comp_t m [3], n [3];
		int scale;
		rows.push_back(make_row(0, 0, 0, 0, 0, 0, 1, zero_degenerate()));
		rows.push_back(make_row(1, 0, 0, 0, 1, 0, 1, z_aligned()));
		rows.push_back(make_row(0, 1, 0, 1, 0, 0, 1, z_aligned()));
		rows.push_back(make_row(3, -5, 7, 6, -10, 14, 1, zero_degenerate()));
		rows.push_back(make_row(-32768, -32768, -32768, -32768, -32768, -32768, 1,
			zero_degenerate()));
		rows.push_back(make_row(32767, 32767, 32767, 0, 0, 0, 1, zero_degenerate()));
		rows.push_back(make_row(-32768, 0, 0, 0, -32768, 0, 1, z_aligned()));
		rows.push_back(make_row(1, 0, 0, 0, 0, 1, 0, '0));
		rows.push_back(make_row(0, 1, 0, 0, 0, 1, 0, '0));
		rows.push_back(make_row(1, 0, 0, 0, 0, -1, 0, '0));
		rows.push_back(make_row(32767, -32768, 32767, -32768, 32767, -32768, 0, '0));
		rows.push_back(make_row(32767, 0, -32768, -32768, 32767, 32767, 0, '0));
		rows.push_back(make_row(-32768, -32768, 32767, 32767, -32768, -32768, 0, '0));
		rows.push_back(make_row(1, 1, 0, -1, 1, 0, 0, '0));
		rows.push_back(make_row(1, 2, 3, 4, 5, 6, 0, '0));
		rows.push_back(make_row(-1, 0, 0, 0, 1, 0, 0, '0));
		rows.push_back(make_row(0, 0, 1, 1, 0, 0, 0, '0));
		rows.push_back(make_row(5, -3, 1, 2, 7, -4, 0, '0));
		rows.push_back(make_row(-1, -1, -1, 1, -1, 1, 0, '0));
		rows.push_back(make_row(21845, -10923, 1, -1, 32767, 16384, 0, '0));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 9;
		recv_stall_pct = 47;
		foreach (rows[i]) send_pair(rows[i].m, rows[i].n, rows[i].has_exp, rows[i].exp_res);

		for (int it = 0; it < N_RANDOM; it++) begin
			if (it == N_RANDOM / 3) begin
				send_idle_pct = 47;
				recv_stall_pct = 9;
			end else if (it == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
				long_hold = 1'b1;
			end
			for (int k = 0; k < 3; k++) m[k] = rand_comp();
			// A few pairs are parallel on purpose so the degenerate path stays busy.
			if ($urandom_range(9) == 0) begin
				scale = $urandom_range(4) - 2;
				for (int k = 0; k < 3; k++) begin
					m[k] = comp_t'(int'($urandom_range(200)) - 100);
					n[k] = comp_t'(m[k] * scale);
				end
			end else begin
				for (int k = 0; k < 3; k++) n[k] = rand_comp();
			end
			send_pair(m, n, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (matrix_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (!failed && matrix_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
